>>> hw/rtl/i2cbb_pkg.sv
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types and constants for the bit-level I2C master sequencer.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

	localparam int unsigned TICK_W = 16;
	localparam int unsigned PHASE_W = 5;
	localparam int unsigned BYTE_W = 8;
	localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd100;

	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4,
		OP_ACK   = 3'd5
	} op_t;

	typedef struct packed {
		logic              scl;
		logic              sda;
		logic              drive;
		logic              busy;
		logic [BYTE_W-1:0] rdata;
		logic              done;
		logic              rej;
	} res_t;

	function automatic logic [PHASE_W-1:0] phase_total(op_t cmd);
		logic [PHASE_W-1:0] n;
		unique case (cmd)
			OP_START: n = 5'd4;
			OP_STOP:  n = 5'd4;
			OP_WRITE: n = 5'd24;
			OP_READ:  n = 5'd16;
			OP_ACK:   n = 5'd1;
			default:  n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

>>> hw/rtl/i2cbb_core.sv
// ----------------------------------------------------------------------------
// i2cbb_core
// Sequencer state and next-state logic; commits one tick per step.
// ----------------------------------------------------------------------------
module i2cbb_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [2:0]                        op,
	input  logic [i2cbb_pkg::BYTE_W-1:0]      data_byte,
	input  logic                              sda_in,
	input  logic [i2cbb_pkg::TICK_W-1:0]      phase_ticks,
	output i2cbb_pkg::res_t                   res
);

	typedef struct packed {
		i2cbb_pkg::op_t                   cmd;
		logic [i2cbb_pkg::PHASE_W-1:0]    phase;
		logic [1:0]                       sub;
		logic [i2cbb_pkg::TICK_W-1:0]     tick;
		logic [i2cbb_pkg::BYTE_W-1:0]     shift;
		logic                             scl;
		logic                             sda;
		logic                             drive;
		logic [i2cbb_pkg::BYTE_W-1:0]     rbyte;
	} seq_t;

	seq_t st_q;
	seq_t st_d;
	logic [i2cbb_pkg::TICK_W-1:0] len;
	logic is_cmd;

	// sub tracks phase mod 3 for write sequences
	function automatic seq_t enter_phase(seq_t s, logic bit_in);
		seq_t r;
		r = s;
		unique case (s.cmd)
			i2cbb_pkg::OP_START: begin
				unique case (s.phase[1:0])
					2'd0: r.sda = 1'b1;
					2'd1: r.scl = 1'b1;
					2'd2: r.sda = 1'b0;
					default: r.scl = 1'b0;
				endcase
			end
			i2cbb_pkg::OP_STOP: begin
				unique case (s.phase[1:0])
					2'd0: r.sda = 1'b0;
					2'd1: r.scl = 1'b0;
					2'd2: r.scl = 1'b1;
					default: r.sda = 1'b1;
				endcase
			end
			i2cbb_pkg::OP_WRITE: begin
				unique case (s.sub)
					2'd0: begin
						r.sda = s.shift[i2cbb_pkg::BYTE_W-1];
						r.shift = {s.shift[i2cbb_pkg::BYTE_W-2:0], 1'b0};
					end
					2'd1: r.scl = 1'b1;
					default: r.scl = 1'b0;
				endcase
			end
			i2cbb_pkg::OP_READ: begin
				if (!s.phase[0]) begin
					r.scl = 1'b1;
				end else begin
					r.shift = {s.shift[i2cbb_pkg::BYTE_W-2:0], bit_in};
					r.scl = 1'b0;
				end
			end
			i2cbb_pkg::OP_ACK: begin
				r.sda = 1'b1;
				r.scl = 1'b1;
			end
			default: r = s;
		endcase
		return r;
	endfunction

	assign len = (phase_ticks == '0) ? {{(i2cbb_pkg::TICK_W-1){1'b0}}, 1'b1} : phase_ticks;
	assign is_cmd = (op >= 3'(i2cbb_pkg::OP_START)) && (op <= 3'(i2cbb_pkg::OP_ACK));

	always_comb begin
		st_d = st_q;
		res.done = 1'b0;
		res.rej = 1'b0;
		if (st_d.cmd != i2cbb_pkg::OP_IDLE && st_d.tick >= len) begin
			st_d.tick = '0;
			st_d.phase = st_d.phase + 5'd1;
			st_d.sub = (st_d.sub == 2'd2) ? 2'd0 : st_d.sub + 2'd1;
			if (st_d.phase >= i2cbb_pkg::phase_total(st_d.cmd)) begin
				if (st_d.cmd == i2cbb_pkg::OP_READ) begin
					st_d.rbyte = st_d.shift;
					st_d.drive = 1'b1;
					res.done = 1'b1;
				end else if (st_d.cmd == i2cbb_pkg::OP_ACK) begin
					st_d.scl = 1'b0;
				end
				st_d.cmd = i2cbb_pkg::OP_IDLE;
				st_d.phase = '0;
				st_d.sub = '0;
			end else begin
				st_d = enter_phase(st_d, sda_in);
			end
		end
		if (is_cmd) begin
			if (st_d.cmd == i2cbb_pkg::OP_IDLE) begin
				st_d.cmd = i2cbb_pkg::op_t'(op);
				st_d.phase = '0;
				st_d.sub = '0;
				st_d.tick = '0;
				if (st_d.cmd == i2cbb_pkg::OP_READ) begin
					st_d.drive = 1'b0;
					st_d.shift = '0;
				end else begin
					st_d.drive = 1'b1;
					if (st_d.cmd == i2cbb_pkg::OP_WRITE) begin
						st_d.shift = data_byte;
					end
				end
				st_d = enter_phase(st_d, sda_in);
			end else begin
				res.rej = 1'b1;
			end
		end
		if (st_d.cmd != i2cbb_pkg::OP_IDLE) begin
			st_d.tick = st_d.tick + 16'd1;
		end
		res.scl = st_d.scl;
		res.sda = st_d.drive ? st_d.sda : 1'b1;
		res.drive = st_d.drive;
		res.busy = (st_d.cmd != i2cbb_pkg::OP_IDLE);
		res.rdata = st_d.rbyte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.cmd <= i2cbb_pkg::OP_IDLE;
			st_q.phase <= '0;
			st_q.sub <= '0;
			st_q.tick <= '0;
			st_q.shift <= '0;
			st_q.scl <= 1'b1;
			st_q.sda <= 1'b1;
			st_q.drive <= 1'b1;
			st_q.rbyte <= '0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

`ifndef SYNTH
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cmd == i2cbb_pkg::OP_IDLE |-> st_q.tick == '0 && st_q.phase == '0)
		else $error("idle sequencer holds stale counters");
	a_release_read: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.drive |-> st_q.cmd == i2cbb_pkg::OP_READ)
		else $error("SDA released outside a read");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cmd != i2cbb_pkg::OP_IDLE |-> st_q.phase < i2cbb_pkg::phase_total(st_q.cmd))
		else $error("phase index past end of sequence");
`endif

endmodule

>>> hw/rtl/i2c_bitbang_master.sv
// ----------------------------------------------------------------------------
// i2c_bitbang_master
// Bit-level I2C master: one tick per item, sequences SCL/SDA phases.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_ready    | op, data_byte, sda_in
//  out     | out_valid / out_ready  | scl_level, sda_level, sda_drive, busy_res,
//          |                        | read_data, read_done, rejected
//  cfg     | cfg_we                 | cfg_wdata (phase_ticks)
//
//  One item per cycle unless the output stalls; path: input register, then result register.
//  The sequencer state commits when an item moves from the input to the result register.
//  Reset: SCL/SDA high and driven, sequencer idle, phase_ticks 100.
//  A stalled output holds the result register; the input register then fills and
//  in_ready drops.
// ----------------------------------------------------------------------------
module i2c_bitbang_master (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [i2cbb_pkg::TICK_W-1:0]      cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        op,
	input  logic [i2cbb_pkg::BYTE_W-1:0]      data_byte,
	input  logic                              sda_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              scl_level,
	output logic                              sda_level,
	output logic                              sda_drive,
	output logic                              busy_res,
	output logic [i2cbb_pkg::BYTE_W-1:0]      read_data,
	output logic                              read_done,
	output logic                              rejected
);

	logic [i2cbb_pkg::TICK_W-1:0] phase_ticks_q;
	logic                         valid_s1;
	logic [2:0]                   op_s1;
	logic [i2cbb_pkg::BYTE_W-1:0] data_s1;
	logic                         sda_s1;
	logic                         valid_s2;
	i2cbb_pkg::res_t              res;
	i2cbb_pkg::res_t              res_s2;
	logic                         advance;

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cbb_pkg::PHASE_TICKS_RST;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op;
			data_s1 <= data_byte;
			sda_s1 <= sda_in;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	i2cbb_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.op          (op_s1),
		.data_byte   (data_s1),
		.sda_in      (sda_s1),
		.phase_ticks (phase_ticks_q),
		.res         (res)
	);

	assign out_valid = valid_s2;
	assign scl_level = res_s2.scl;
	assign sda_level = res_s2.sda;
	assign sda_drive = res_s2.drive;
	assign busy_res = res_s2.busy;
	assign read_data = res_s2.rdata;
	assign read_done = res_s2.done;
	assign rejected = res_s2.rej;

`ifndef SYNTH
	a_done_not_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_done |-> !rejected)
		else $error("read completion and rejection on the same item");
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res)
		else $error("command rejected while sequencer idle");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1))
		else $error("input register lost a stalled item");
`endif

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the bit-level I2C master one tick per item with random idle on both
// channels. A scoreboard class steps its own copy of the SCL/SDA sequencer for
// every accepted tick and checks each result field in order. The run covers
// the reset phase length, zero, one, small values and the largest value,
// directed commands first, then random transfers with noise mixed in.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_UNUSED6 = 3'd6;
	localparam logic [2:0] OP_UNUSED7 = 3'd7;
	localparam int QUIET_LIMIT = 1000;

	typedef struct {
		logic [2:0] op;
		logic [7:0] data;
		logic       sda;
	} item_t;

	typedef struct {
		logic [2:0] op;
		logic [7:0] data;
		logic       sda;
		bit         now;
	} drill_t;

	class bus_pin_scoreboard;
		logic [15:0]     phase_ticks;
		i2cbb_pkg::op_t  cmd;
		logic [4:0]      phase_idx;
		logic [15:0]     ticks;
		logic [7:0]      shreg;
		logic            scl;
		logic            sda;
		logic            drv;
		logic [7:0]      rbyte;
		i2cbb_pkg::res_t pin_levels_due[$];
		int              errors, n_checked, n_started, n_refused, n_reads;

		function new();
			phase_ticks = i2cbb_pkg::PHASE_TICKS_RST;
			cmd = i2cbb_pkg::OP_IDLE;
			phase_idx = '0;
			ticks = '0;
			shreg = '0;
			scl = 1'b1;
			sda = 1'b1;
			drv = 1'b1;
			rbyte = '0;
		endfunction

		function int unsigned eff_len();
			return (phase_ticks == 0) ? 1 : phase_ticks;
		endfunction

		function int unsigned phases_of(i2cbb_pkg::op_t c);
			case (c)
				i2cbb_pkg::OP_START, i2cbb_pkg::OP_STOP: return 4;
				i2cbb_pkg::OP_WRITE:                     return 24;
				i2cbb_pkg::OP_READ:                      return 16;
				i2cbb_pkg::OP_ACK:                       return 1;
				default:                                 return 0;
			endcase
		endfunction

		// true when the next tick finds the sequencer free for a command
		function bit frees_next();
			return cmd == i2cbb_pkg::OP_IDLE ||
				(ticks >= eff_len() && phase_idx + 1 >= phases_of(cmd));
		endfunction

		function void enter_phase(logic [4:0] p, logic s);
			case (cmd)
				i2cbb_pkg::OP_START: begin
					case (p)
						0:       sda = 1'b1;
						1:       scl = 1'b1;
						2:       sda = 1'b0;
						default: scl = 1'b0;
					endcase
				end
				i2cbb_pkg::OP_STOP: begin
					case (p)
						0:       sda = 1'b0;
						1:       scl = 1'b0;
						2:       scl = 1'b1;
						default: sda = 1'b1;
					endcase
				end
				i2cbb_pkg::OP_WRITE: begin
					case (p % 3)
						0: begin
							sda = shreg[7];
							shreg = shreg << 1;
						end
						1:       scl = 1'b1;
						default: scl = 1'b0;
					endcase
				end
				i2cbb_pkg::OP_READ: begin
					if (p[0] == 1'b0) begin
						scl = 1'b1;
					end else begin
						shreg = {shreg[6:0], s};
						scl = 1'b0;
					end
				end
				i2cbb_pkg::OP_ACK: begin
					sda = 1'b1;
					scl = 1'b1;
				end
				default: ;
			endcase
		endfunction

		function void note_tick(logic [2:0] o, logic [7:0] d, logic s);
			i2cbb_pkg::res_t r;
			r = '0;
			if (cmd != i2cbb_pkg::OP_IDLE && ticks >= eff_len()) begin
				ticks = '0;
				phase_idx++;
				if (phase_idx >= phases_of(cmd)) begin
					if (cmd == i2cbb_pkg::OP_READ) begin
						rbyte = shreg;
						r.done = 1'b1;
						drv = 1'b1;
						n_reads++;
					end else if (cmd == i2cbb_pkg::OP_ACK) begin
						scl = 1'b0;
					end
					cmd = i2cbb_pkg::OP_IDLE;
					phase_idx = '0;
				end else begin
					enter_phase(phase_idx, s);
				end
			end
			if (o >= i2cbb_pkg::OP_START && o <= i2cbb_pkg::OP_ACK) begin
				if (cmd == i2cbb_pkg::OP_IDLE) begin
					cmd = i2cbb_pkg::op_t'(o);
					phase_idx = '0;
					ticks = '0;
					drv = (cmd != i2cbb_pkg::OP_READ);
					if (cmd == i2cbb_pkg::OP_READ) shreg = '0;
					else if (cmd == i2cbb_pkg::OP_WRITE) shreg = d;
					n_started++;
					enter_phase(5'd0, s);
				end else begin
					r.rej = 1'b1;
					n_refused++;
				end
			end
			if (cmd != i2cbb_pkg::OP_IDLE) ticks++;
			r.scl = scl;
			r.sda = drv ? sda : 1'b1;
			r.drive = drv;
			r.busy = (cmd != i2cbb_pkg::OP_IDLE);
			r.rdata = rbyte;
			pin_levels_due.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("tb: mismatch: %s", msg);
		endtask

		task cmp(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %0h want %0h", n_checked, name, got, want));
		endtask

		task check_pins(i2cbb_pkg::res_t got);
			i2cbb_pkg::res_t want;
			if (pin_levels_due.size() == 0) begin
				report("result with nothing predicted");
				return;
			end
			want = pin_levels_due.pop_front();
			cmp("scl_level", got.scl, want.scl);
			cmp("sda_level", got.sda, want.sda);
			cmp("sda_drive", got.drive, want.drive);
			cmp("busy_res", got.busy, want.busy);
			cmp("read_data", got.rdata, want.rdata);
			cmp("read_done", got.done, want.done);
			cmp("rejected", got.rej, want.rej);
			n_checked++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  op = i2cbb_pkg::OP_IDLE;
	logic [7:0]  data_byte = '0;
	logic        sda_in = 1'b1;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        scl_level, sda_level, sda_drive, busy_res, read_done, rejected;
	logic [7:0]  read_data;

	bus_pin_scoreboard pins_sb = new();
	item_t             plan[$];
	bit                calm = 1'b0;
	logic              fill_sda = 1'b1;
	int                quiet = 0;

	drill_t drill [0:19] = '{
		'{i2cbb_pkg::OP_START, 8'h00, 1'b1, 1'b0},
		'{i2cbb_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b0},
		'{i2cbb_pkg::OP_WRITE, 8'h00, 1'b1, 1'b1},
		'{OP_UNUSED6,          8'h5A, 1'b0, 1'b1},
		'{i2cbb_pkg::OP_ACK,   8'h00, 1'b0, 1'b0},
		'{i2cbb_pkg::OP_WRITE, 8'h00, 1'b0, 1'b0},
		'{i2cbb_pkg::OP_ACK,   8'hFF, 1'b1, 1'b0},
		'{i2cbb_pkg::OP_WRITE, 8'hA5, 1'b1, 1'b0},
		'{i2cbb_pkg::OP_READ,  8'h00, 1'b1, 1'b0},
		'{i2cbb_pkg::OP_ACK,   8'h00, 1'b0, 1'b0},
		'{i2cbb_pkg::OP_READ,  8'hFF, 1'b0, 1'b0},
		'{i2cbb_pkg::OP_STOP,  8'h00, 1'b0, 1'b1},
		'{OP_UNUSED7,          8'hC3, 1'b1, 1'b1},
		'{i2cbb_pkg::OP_READ,  8'h00, 1'b1, 1'b0},
		'{i2cbb_pkg::OP_ACK,   8'h00, 1'b1, 1'b0},
		'{i2cbb_pkg::OP_STOP,  8'h00, 1'b1, 1'b0},
		'{OP_UNUSED7,          8'h00, 1'b0, 1'b0},
		'{i2cbb_pkg::OP_START, 8'h00, 1'b0, 1'b0},
		'{i2cbb_pkg::OP_START, 8'h00, 1'b1, 1'b1},
		'{i2cbb_pkg::OP_STOP,  8'h00, 1'b1, 1'b0}
	};

	i2c_bitbang_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.data_byte (data_byte),
		.sda_in    (sda_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scl_level (scl_level),
		.sda_level (sda_level),
		.sda_drive (sda_drive),
		.busy_res  (busy_res),
		.read_data (read_data),
		.read_done (read_done),
		.rejected  (rejected)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 19);
	end

	always @(posedge clk) begin
		i2cbb_pkg::res_t got;
		if (arst_n && out_valid && out_ready) begin
			got.scl = scl_level;
			got.sda = sda_level;
			got.drive = sda_drive;
			got.busy = busy_res;
			got.rdata = read_data;
			got.done = read_done;
			got.rej = rejected;
			pins_sb.check_pins(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb: no handshake for %0d cycles", quiet);
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// one transfer: start, address, then a few data bytes each with an ack clock, stop
	function automatic void plan_transfer();
		int n;
		n = $urandom_range(1, 3);
		plan.push_back('{i2cbb_pkg::OP_START, 8'($urandom), 1'b0});
		plan.push_back('{i2cbb_pkg::OP_WRITE, 8'($urandom), 1'b0});
		plan.push_back('{i2cbb_pkg::OP_ACK, 8'($urandom), 1'b0});
		repeat (n) begin
			plan.push_back('{($urandom_range(1) ? i2cbb_pkg::OP_READ : i2cbb_pkg::OP_WRITE),
				8'($urandom), 1'b0});
			plan.push_back('{i2cbb_pkg::OP_ACK, 8'($urandom), 1'b0});
		end
		plan.push_back('{i2cbb_pkg::OP_STOP, 8'($urandom), 1'b0});
	endfunction

	function automatic item_t pick_item();
		item_t it;
		it.op = i2cbb_pkg::OP_IDLE;
		it.data = 8'($urandom);
		it.sda = 1'($urandom);
		if ($urandom_range(99) < 15) begin
			it.op = 3'($urandom_range(7));
		end else if (pins_sb.frees_next()) begin
			if (plan.size() == 0) plan_transfer();
			if ($urandom_range(3) != 0) begin
				it.op = plan[0].op;
				if (plan[0].op == i2cbb_pkg::OP_WRITE) it.data = plan[0].data;
				void'(plan.pop_front());
			end
		end else if ($urandom_range(29) == 0) begin
			it.op = 3'($urandom_range(i2cbb_pkg::OP_START, i2cbb_pkg::OP_ACK));
		end
		return it;
	endfunction

	task automatic send_item(input item_t it);
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		data_byte <= it.data;
		sda_in <= it.sda;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pins_sb.note_tick(it.op, it.data, it.sda);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pins_sb.pin_levels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_phase_ticks(input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pins_sb.phase_ticks = v;
	endtask

	task automatic run_random(input int n);
		repeat (n) send_item(pick_item());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset phase length: a start that stays in its first phase
		send_item('{i2cbb_pkg::OP_START, 8'h00, 1'b1});
		repeat (20) send_item('{i2cbb_pkg::OP_IDLE, 8'($urandom), 1'($urandom)});
		send_item('{i2cbb_pkg::OP_WRITE, 8'h3C, 1'b0});
		send_item('{OP_UNUSED6, 8'h00, 1'b1});
		settle();

		// zero length acts as one tick per phase
		set_phase_ticks(16'd0);
		foreach (drill[i]) begin
			while (!drill[i].now && !pins_sb.frees_next())
				send_item('{i2cbb_pkg::OP_IDLE, 8'($urandom), fill_sda});
			send_item('{drill[i].op, drill[i].data, drill[i].sda});
			fill_sda = drill[i].sda;
		end
		settle();

		set_phase_ticks(16'd1);
		calm = 1'b1;
		run_random(220);
		calm = 1'b0;
		settle();

		set_phase_ticks(16'd2);
		run_random(160);
		settle();

		set_phase_ticks(16'hFFFF);
		run_random(60);
		settle();

		set_phase_ticks(16'd3);
		run_random(160);
		settle();

		set_phase_ticks(16'd1);
		run_random(40);
		settle();

		$display("tb: %0d ticks checked, %0d commands run, %0d refused while busy, %0d reads",
			pins_sb.n_checked, pins_sb.n_started, pins_sb.n_refused, pins_sb.n_reads);
		$display("tb: phase lengths 100, 0, 1, 2, 3 and 65535, %0d mismatches", pins_sb.errors);
		if (pins_sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
